/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GBB_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBB_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/gbb_pkg.sv */
// types, constants and divide helpers for the gray + 3x3 box blur core
// no dependencies
`default_nettype none

package gbb_pkg;

   localparam int CHANNEL_BITS  = 8;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int WIDTH_BITS    = 11;
   localparam int HEIGHT_BITS   = 16;
   localparam int GRAY_SUM_BITS = CHANNEL_BITS + 2;
   localparam int SUM_BITS      = CHANNEL_BITS + 4;

   // (r+g+b)/3 and sum/9 as multiply by reciprocal, exact over the value range
   localparam int DIV3_MUL   = 683;
   localparam int DIV3_SHIFT = 11;
   localparam int DIV9_MUL   = 3641;
   localparam int DIV9_SHIFT = 15;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRAY_FIRST   = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic [WIDTH_BITS-1:0]  RST_FRAME_WIDTH  = 11'd640;
   localparam logic [HEIGHT_BITS-1:0] RST_FRAME_HEIGHT = 16'd480;
   localparam logic                   RST_GRAY_FIRST   = 1'b1;

   localparam int RSP_DEPTH    = 8;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [SUM_BITS-1:0]     sum_type;

   typedef struct packed {
      chan_type blue;
      chan_type green;
      chan_type red;
   } pix_type;

   typedef struct packed {
      pix_type prev;
      pix_type prev2;
   } line_entry_type;

   typedef struct packed {
      logic    last;
      pix_type pix;
   } rsp_item_type;

   function automatic chan_type div3(logic [GRAY_SUM_BITS-1:0] s);
      logic [2*GRAY_SUM_BITS-1:0] prod;
      prod = (2*GRAY_SUM_BITS)'(s) * (2*GRAY_SUM_BITS)'(DIV3_MUL);
      return prod[DIV3_SHIFT +: CHANNEL_BITS];
   endfunction

   function automatic chan_type div9(sum_type s);
      logic [2*SUM_BITS-1:0] prod;
      prod = (2*SUM_BITS)'(s) * (2*SUM_BITS)'(DIV9_MUL);
      return prod[DIV9_SHIFT +: CHANNEL_BITS];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/gray_then_box_blur_3x3_core.sv */
// gray conversion and 3x3 box blur over a raster pixel stream
// depends on gbb_pkg
//
// req_ channel: one pixel per transfer in raster order (tuser low), or a flush
// (tuser high) that drains one pending pixel after the frame's last pixel.
// rsp_ channel: processed pixels in raster order, tlast on the frame's last one.
// csr_ channel: writes frame_width (0), frame_height (1), gray_first (2); always
// ready. A geometry write restarts the frame.
// Throughput: one transfer per cycle while req_tready is high. The line store is one
// memory holding both rows above; it is read every cycle and written once per pixel,
// with the write of one pixel forwarded to a read of the same column in the same cycle.
// Path: each transfer passes registered stages 1, 2 and 3, then the result queue; results
// lag the input by one row plus one pixel, the last ones drained by later flushes or pixels.
// Stall: an 8-entry result queue follows the pipeline; req_tready drops only
// when queue and pipeline together hold 8 items.
// Reset: positions to zero, registers to 640 x 480 with gray on, queue empty.
// The line store is not cleared; rows not yet written never reach a result.
`default_nettype none

module gray_then_box_blur_3x3_core #(
   parameter int MAX_WIDTH = gbb_pkg::DEF_MAX_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // in_red, in_green, in_blue
   input  logic [3*gbb_pkg::CHANNEL_BITS-1:0]   req_tdata,
   // command
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // out_red, out_green, out_blue
   output logic [3*gbb_pkg::CHANNEL_BITS-1:0]   rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gbb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gbb_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import gbb_pkg::*;

   localparam int COL_BITS = $clog2(MAX_WIDTH);
   localparam int CNT_BITS = COL_BITS + 1;

   typedef struct packed {
      logic valid;
      logic wr;
      logic emit;
      logic interior;
      logic last;
      logic sel_prev;
   } ctl_type;

   // configuration and positions
   logic [WIDTH_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;
   logic                   gray_first_ff, gray_first_in;
   logic [COL_BITS-1:0]    in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [HEIGHT_BITS-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;

   // pipeline
   ctl_type                s1_ctl_ff, s1_ctl_in, s2_ctl_ff, s3_ctl_ff;
   logic [COL_BITS-1:0]    s1_addr_ff;
   pix_type                s1_pix_ff, s1_pix_in;
   logic                   fwd_ff, fwd_in;
   line_entry_type         fwd_data_ff;
   line_entry_type         mem_q_ff;
   pix_type                window_ff [0:8];
   pix_type                window_in [0:8];
   pix_type                s2_val_ff, s2_val_in;
   pix_type                s3_val_ff;
   sum_type                s3_sum_red_ff, s3_sum_green_ff, s3_sum_blue_ff;

   // result queue
   rsp_item_type           rsp_fifo [0:RSP_DEPTH-1];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_BITS-1:0] count_ff, count_in, used_ff, used_in;

   line_entry_type         line_mem [0:MAX_WIDTH-1];

   logic [CNT_BITS-1:0]    eff_w, in_col_p1, out_col_p1, out_col_p2;
   logic [HEIGHT_BITS-1:0] eff_h;
   logic [HEIGHT_BITS:0]   h_ext, out_row_p1, out_row_p2;
   logic                   accept, complete, ready, pix_op, emit, last, interior;
   logic                   geom_wr;
   logic [COL_BITS-1:0]    rd_addr;
   pix_type                in_pix;
   logic [GRAY_SUM_BITS-1:0] gray_sum;
   chan_type               gray;
   line_entry_type         rd_entry, mem_wdata;
   logic                   mem_we;
   sum_type                sum_red, sum_green, sum_blue;
   pix_type                out_pix;
   logic                   push, pop, drop;
   rsp_item_type           head;

   assign csr_ready  = 1'b1;
   assign req_tready = (used_ff < RSP_CNT_BITS'(RSP_DEPTH));
   assign accept     = req_tvalid && req_tready;

   // effective geometry
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = CNT_BITS'(1);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         eff_w = CNT_BITS'(MAX_WIDTH);
      end else begin
         eff_w = CNT_BITS'(frame_width_ff);
      end
      eff_h = (frame_height_ff == '0) ? HEIGHT_BITS'(1) : frame_height_ff;
   end

   // stage 0: position bookkeeping and gray step
   always_comb begin
      h_ext      = {1'b0, eff_h};
      in_col_p1  = CNT_BITS'(in_col_ff) + CNT_BITS'(1);
      out_col_p1 = CNT_BITS'(out_col_ff) + CNT_BITS'(1);
      out_col_p2 = CNT_BITS'(out_col_ff) + CNT_BITS'(2);
      out_row_p1 = {1'b0, out_row_ff} + (HEIGHT_BITS+1)'(1);
      out_row_p2 = {1'b0, out_row_ff} + (HEIGHT_BITS+1)'(2);

      complete = (in_row_ff >= eff_h);
      // one row plus one pixel already in
      ready    = (in_row_ff >= HEIGHT_BITS'(2)) ||
                 ((in_row_ff == HEIGHT_BITS'(1)) && (in_col_ff != '0));
      interior = (out_row_ff != '0) && (out_row_p2 <= h_ext) &&
                 (out_col_ff != '0) && (out_col_p2 <= eff_w);
      last     = (out_row_p1 == h_ext) && (out_col_p1 == eff_w);
      pix_op   = accept && !complete && (req_tuser == CMD_PIXEL);
      emit     = accept && (complete || ((req_tuser == CMD_PIXEL) && ready));
      rd_addr  = complete ? out_col_ff : in_col_ff;

      in_pix   = pix_type'(req_tdata);
      gray_sum = GRAY_SUM_BITS'(in_pix.red) + GRAY_SUM_BITS'(in_pix.green) +
                 GRAY_SUM_BITS'(in_pix.blue);
      gray     = div3(gray_sum);
      s1_pix_in = gray_first_ff ? pix_type'{blue: gray, green: gray, red: gray} : in_pix;

      s1_ctl_in.valid    = accept;
      s1_ctl_in.wr       = pix_op;
      s1_ctl_in.emit     = emit;
      s1_ctl_in.interior = interior;
      s1_ctl_in.last     = last;
      s1_ctl_in.sel_prev = (out_row_p1 >= h_ext);
   end

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      gray_first_in   = gray_first_ff;
      in_col_in       = in_col_ff;
      in_row_in       = in_row_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      geom_wr         = 1'b0;

      if (pix_op) begin
         if (in_col_p1 >= eff_w) begin
            in_col_in = '0;
            in_row_in = in_row_ff + HEIGHT_BITS'(1);
         end else begin
            in_col_in = in_col_p1[COL_BITS-1:0];
         end
      end

      if (emit) begin
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else if (out_col_p1 >= eff_w) begin
            out_col_in = '0;
            out_row_in = out_row_ff + HEIGHT_BITS'(1);
         end else begin
            out_col_in = out_col_p1[COL_BITS-1:0];
         end
      end

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_in = csr_data[WIDTH_BITS-1:0];
               geom_wr        = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_data[HEIGHT_BITS-1:0];
               geom_wr         = 1'b1;
            end
            CSR_GRAY_FIRST: begin
               gray_first_in = csr_data[0];
            end
            default: begin
            end
         endcase
      end

      if (geom_wr) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   // stage 1: line store read-modify-write and window shift
   always_comb begin
      rd_entry  = fwd_ff ? fwd_data_ff : mem_q_ff;
      mem_we    = s1_ctl_ff.valid && s1_ctl_ff.wr;
      mem_wdata = line_entry_type'{prev: s1_pix_ff, prev2: rd_entry.prev};
      // a read of the column being written this cycle would see stale data
      fwd_in    = mem_we && (s1_addr_ff == rd_addr);

      for (int k = 0; k < 9; k++) begin
         window_in[k] = window_ff[k];
      end
      if (mem_we) begin
         for (int k = 0; k < 3; k++) begin
            window_in[3*k]     = window_ff[3*k + 1];
            window_in[3*k + 1] = window_ff[3*k + 2];
         end
         window_in[2] = rd_entry.prev2;
         window_in[5] = rd_entry.prev;
         window_in[8] = s1_pix_ff;
      end

      // centre of the shifted window is the pixel being emitted
      if (s1_ctl_ff.wr) begin
         s2_val_in = window_ff[5];
      end else begin
         s2_val_in = s1_ctl_ff.sel_prev ? rd_entry.prev : rd_entry.prev2;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[s1_addr_ff] <= mem_wdata;
      end
      mem_q_ff <= line_mem[rd_addr];
   end

   // stage 2: channel sums over the window
   always_comb begin
      sum_red   = '0;
      sum_green = '0;
      sum_blue  = '0;
      for (int j = 0; j < 9; j++) begin
         sum_red   = sum_red   + SUM_BITS'(window_ff[j].red);
         sum_green = sum_green + SUM_BITS'(window_ff[j].green);
         sum_blue  = sum_blue  + SUM_BITS'(window_ff[j].blue);
      end
   end

   // stage 3: mean and result queue
   always_comb begin
      if (s3_ctl_ff.interior) begin
         out_pix = pix_type'{blue:  div9(s3_sum_blue_ff),
                             green: div9(s3_sum_green_ff),
                             red:   div9(s3_sum_red_ff)};
      end else begin
         out_pix = s3_val_ff;
      end
      push     = s3_ctl_ff.valid && s3_ctl_ff.emit;
      drop     = s3_ctl_ff.valid && !s3_ctl_ff.emit;
      head     = rsp_fifo[rd_ptr_ff];
      pop      = (count_ff != '0) && rsp_tready;
      count_in = count_ff + RSP_CNT_BITS'(push) - RSP_CNT_BITS'(pop);
      used_in  = used_ff + RSP_CNT_BITS'(accept) - RSP_CNT_BITS'(drop) -
                 RSP_CNT_BITS'(pop);
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = head.pix;
   assign rsp_tlast  = head.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         gray_first_ff   <= RST_GRAY_FIRST;
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         out_col_ff      <= '0;
         out_row_ff      <= '0;
         s1_ctl_ff       <= '0;
         s2_ctl_ff       <= '0;
         s3_ctl_ff       <= '0;
         fwd_ff          <= 1'b0;
         wr_ptr_ff       <= '0;
         rd_ptr_ff       <= '0;
         count_ff        <= '0;
         used_ff         <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         gray_first_ff   <= gray_first_in;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         out_col_ff      <= out_col_in;
         out_row_ff      <= out_row_in;
         s1_ctl_ff       <= s1_ctl_in;
         s2_ctl_ff       <= s1_ctl_ff;
         s3_ctl_ff       <= s2_ctl_ff;
         fwd_ff          <= fwd_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_BITS'(1);
         end
         count_ff        <= count_in;
         used_ff         <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff      <= rd_addr;
      s1_pix_ff       <= s1_pix_in;
      fwd_data_ff     <= mem_wdata;
      window_ff       <= window_in;
      s2_val_ff       <= s2_val_in;
      s3_val_ff       <= s2_val_ff;
      s3_sum_red_ff   <= sum_red;
      s3_sum_green_ff <= sum_green;
      s3_sum_blue_ff  <= sum_blue;
      if (push) begin
         rsp_fifo[wr_ptr_ff] <= rsp_item_type'{last: s3_ctl_ff.last, pix: out_pix};
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/gbb_checker.sv */
// port-level checks for the gray + box blur core, bound to its top level
// depends on gbb_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module gbb_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [3*gbb_pkg::CHANNEL_BITS-1:0] rsp_tdata,
   input logic                               rsp_tlast
);
   import gbb_pkg::*;

   // a stalled result keeps its payload
   `GBB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "result changed while stalled")

   // reset empties the result queue
   `GBB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid, "result valid after reset")

   // reset releases all input credit
   `GBB_ASSERT_NEXT(a_reset_ready, clock, 1'b0, reset, req_tready, "input not ready after reset")

endmodule

bind gray_then_box_blur_3x3_core gbb_checker u_gbb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

/* tb/gray_then_box_blur_3x3_core_tb.sv */
`timescale 1ns / 100ps
// self-checking bench for the gray + 3x3 box blur core: bursty pixel and flush
// traffic, a stalling receiver, results predicted in order and compared per field
// depends on gbb_pkg and gray_then_box_blur_3x3_core

module gray_then_box_blur_3x3_core_tb;
   import gbb_pkg::*;

   localparam int LINE_DEPTH    = DEF_MAX_WIDTH;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int ITEM_COUNT    = 400;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE = 2'd3;

   class blur_scoreboard;
      pix_type                line_prev [LINE_DEPTH];
      pix_type                line_prev2 [LINE_DEPTH];
      pix_type                win [9];
      int unsigned            in_col, in_row, out_col, out_row;
      logic [WIDTH_BITS-1:0]  frame_w;
      logic [HEIGHT_BITS-1:0] frame_h;
      logic                   gray_on;
      rsp_item_type           expected_pixels [$];
      int unsigned            mismatches;

      function new();
         foreach (line_prev[i]) begin
            line_prev[i] = '0;
            line_prev2[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         restart_frame();
         frame_w = RST_FRAME_WIDTH;
         frame_h = RST_FRAME_HEIGHT;
         gray_on = RST_GRAY_FIRST;
         mismatches = 0;
      endfunction

      function void restart_frame();
         in_col = 0;
         in_row = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      function int unsigned active_width();
         if (frame_w == 0) return 1;
         if (frame_w > LINE_DEPTH) return LINE_DEPTH;
         return frame_w;
      endfunction

      function int unsigned active_height();
         return (frame_h == 0) ? 1 : frame_h;
      endfunction

      function int unsigned pending();
         return expected_pixels.size();
      endfunction

      function void note_register(logic [CSR_INDEX_BITS-1:0] idx,
                                  logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_FRAME_WIDTH: begin
               frame_w = data[WIDTH_BITS-1:0];
               restart_frame();
            end
            CSR_FRAME_HEIGHT: begin
               frame_h = data[HEIGHT_BITS-1:0];
               restart_frame();
            end
            CSR_GRAY_FIRST: gray_on = data[0];
            default: ;
         endcase
      endfunction

      function void emit_pixel(pix_type v, int unsigned w, int unsigned h);
         rsp_item_type item;
         item.pix = v;
         item.last = (out_row + 1 == h) && (out_col + 1 == w);
         expected_pixels.push_back(item);
         if (item.last) restart_frame();
         else if (out_col + 1 >= w) begin
            out_col = 0;
            out_row++;
         end else out_col++;
      endfunction

      function void note_input(logic cmd, pix_type px);
         int unsigned w, h, col, ocol, sum3, j, k;
         int unsigned acc [3];
         bit          ready;
         pix_type     up1, up2, rim;
         w = active_width();
         h = active_height();
         // frame fully received: any item drains one pending pixel
         if (in_row >= h) begin
            ocol = out_col % LINE_DEPTH;
            emit_pixel((out_row + 1 >= h) ? line_prev[ocol] : line_prev2[ocol], w, h);
            return;
         end
         if (cmd == CMD_FLUSH) return;
         if (gray_on) begin
            sum3 = int'(px.red) + int'(px.green) + int'(px.blue);
            px.red = chan_type'(sum3 / 3);
            px.green = chan_type'(sum3 / 3);
            px.blue = chan_type'(sum3 / 3);
         end
         col = in_col % LINE_DEPTH;
         ocol = out_col % LINE_DEPTH;
         rim = line_prev2[ocol];
         up2 = line_prev2[col];
         up1 = line_prev[col];
         for (k = 0; k < 3; k++) begin
            win[3*k] = win[3*k+1];
            win[3*k+1] = win[3*k+2];
         end
         win[2] = up2;
         win[5] = up1;
         win[8] = px;
         line_prev2[col] = up1;
         line_prev[col] = px;
         ready = (in_row * w + in_col) >= w + 1;
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else in_col++;
         if (!ready) return;
         if (out_row >= 1 && out_row + 2 <= h && out_col >= 1 && out_col + 2 <= w) begin
            acc[0] = 0;
            acc[1] = 0;
            acc[2] = 0;
            for (j = 0; j < 9; j++) begin
               acc[0] += win[j].red;
               acc[1] += win[j].green;
               acc[2] += win[j].blue;
            end
            rim.red = chan_type'(acc[0] / 9);
            rim.green = chan_type'(acc[1] / 9);
            rim.blue = chan_type'(acc[2] / 9);
         end
         emit_pixel(rim, w, h);
      endfunction

      function void compare_field(string label, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
            mismatches++;
         end
      endfunction

      function void check_output(pix_type got, logic got_last);
         rsp_item_type want;
         if (expected_pixels.size() == 0) begin
            $display("%0t: output pixel with none expected, got r=%0d g=%0d b=%0d last=%0b",
                     $time, got.red, got.green, got.blue, got_last);
            mismatches++;
            return;
         end
         want = expected_pixels.pop_front();
         compare_field("red", want.pix.red, got.red);
         compare_field("green", want.pix.green, got.green);
         compare_field("blue", want.pix.blue, got.blue);
         compare_field("last", {7'b0, want.last}, {7'b0, got_last});
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [3*CHANNEL_BITS-1:0] req_tdata = '0;
   logic                      req_tuser = CMD_PIXEL;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [3*CHANNEL_BITS-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   blur_scoreboard blur_sb = new();
   int unsigned    cycles_run = 0;
   int unsigned    items_sent = 0;
   int unsigned    burst_left = 0;
   bit             hold_request = 1'b0;
   bit             hold_done = 1'b0;
   int unsigned    stall_left = 0;
   int unsigned    mode_left = 0;
   int unsigned    stall_mode = 0;

   gray_then_box_blur_3x3_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // every transfer is seen here, with the values from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) blur_sb.note_register(csr_index, csr_data);
         if (rsp_tvalid && rsp_tready) blur_sb.check_output(pix_type'(rsp_tdata), rsp_tlast);
         if (req_tvalid && req_tready) blur_sb.note_input(req_tuser, pix_type'(req_tdata));
      end
   end

   // receiver: changing stall patterns, plus one long hold-off during the pressure frame
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (hold_request && !hold_done) begin
         hold_done = 1'b1;
         stall_left = 400;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 80);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic pix_type rand_pixel();
      pix_type v;
      int      k;
      v = pix_type'($urandom());
      for (k = 0; k < 3; k++)
         case ($urandom_range(0, 9))
            0: v[8*k +: 8] = 8'h00;
            1: v[8*k +: 8] = 8'hFF;
            default: ;
         endcase
      return v;
   endfunction

   task automatic send_item(input logic cmd, input pix_type data);
      int unsigned gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 9))
            0: begin
               gap = 0;
               burst_left = $urandom_range(40, 120);
            end
            1: begin
               gap = $urandom_range(5, 15);
               burst_left = $urandom_range(1, 8);
            end
            default: begin
               gap = $urandom_range(0, 3);
               burst_left = $urandom_range(1, 16);
            end
         endcase
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_sent++;
   endtask

   // leaves csr_valid high so that back-to-back writes need no second assignment
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic csr_release();
      csr_valid <= 1'b0;
   endtask

   // lets the last transfer be noted, waits until all expected pixels are out, then
   // lets a flush still in the pipe finish
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (blur_sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_geometry(input int unsigned w_raw, input int unsigned h_raw,
                               input bit with_gray);
      logic [CSR_DATA_BITS-1:0] w_data;
      w_data = CSR_DATA_BITS'($urandom());
      w_data[WIDTH_BITS-1:0] = WIDTH_BITS'(w_raw);
      if ($urandom_range(0, 1) != 0) begin
         write_csr(CSR_FRAME_WIDTH, w_data);
         write_csr(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(h_raw));
      end else begin
         write_csr(CSR_FRAME_HEIGHT, CSR_DATA_BITS'(h_raw));
         write_csr(CSR_FRAME_WIDTH, w_data);
      end
      if (with_gray) write_csr(CSR_GRAY_FIRST, CSR_DATA_BITS'($urandom()));
      csr_release();
   endtask

   task automatic run_frame(input int unsigned w_eff, input int unsigned h_eff,
                            input bit may_break, input bit hold_off);
      int unsigned total, stop_at, drains, k;
      total = w_eff * h_eff;
      stop_at = total;
      if (may_break && total > 1 && $urandom_range(0, 9) == 0)
         stop_at = $urandom_range(1, total - 1);
      for (k = 0; k < stop_at; k++) begin
         // stray flush inside the frame, dropped by the block
         if ($urandom_range(0, 24) == 0) send_item(CMD_FLUSH, rand_pixel());
         if (may_break && $urandom_range(0, 99) == 0) begin
            settle();
            write_csr(CSR_GRAY_FIRST, CSR_DATA_BITS'($urandom()));
            csr_release();
         end
         if (hold_off && k == 12) hold_request = 1'b1;
         send_item(CMD_PIXEL, rand_pixel());
      end
      if (stop_at == total) begin
         // a pixel after the frame's end drains like a flush
         drains = (total < w_eff + 1) ? total : w_eff + 1;
         for (k = 0; k < drains; k++)
            send_item(($urandom_range(0, 6) == 0) ? CMD_PIXEL : CMD_FLUSH, rand_pixel());
         if ($urandom_range(0, 3) == 0) send_item(CMD_FLUSH, rand_pixel());
      end
   endtask

   initial begin
      pix_type     corner_pixels [9];
      int unsigned w_raw, h_raw, w_eff, h_eff, phase, k;
      // red held low and blue high on every pixel to hit both ends of the mean
      corner_pixels = '{24'hFF0000, 24'hFFFF00, 24'hFF8000, 24'hFFFF00, 24'hFF0000,
                        24'hFFFF00, 24'hFF0000, 24'hFF7F00, 24'hFFFF00};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_csr(CSR_SPARE, 16'hFFFF);
      csr_release();
      // reset geometry: nothing comes out yet, flush before the frame ends is dropped
      send_item(CMD_PIXEL, 24'hFFFFFF);
      send_item(CMD_PIXEL, 24'h000000);
      send_item(CMD_FLUSH, 24'hFFFFFF);
      settle();
      write_csr(CSR_FRAME_WIDTH, 16'hF803);
      write_csr(CSR_FRAME_HEIGHT, 16'h0003);
      write_csr(CSR_GRAY_FIRST, 16'hFFFE);
      csr_release();
      foreach (corner_pixels[i]) send_item(CMD_PIXEL, corner_pixels[i]);
      send_item(CMD_FLUSH, 24'h000000);
      send_item(CMD_PIXEL, 24'h123456);
      send_item(CMD_FLUSH, 24'h000000);
      send_item(CMD_FLUSH, 24'h000000);
      send_item(CMD_FLUSH, 24'hFFFFFF);
      settle();
      // zero width and height act as a single pixel
      write_csr(CSR_FRAME_WIDTH, 16'h0000);
      write_csr(CSR_FRAME_HEIGHT, 16'h0000);
      write_csr(CSR_GRAY_FIRST, 16'h0001);
      csr_release();
      send_item(CMD_PIXEL, 24'hFFFFFF);
      send_item(CMD_FLUSH, 24'h000000);
      send_item(CMD_PIXEL, 24'h000001);
      send_item(CMD_FLUSH, 24'h000000);

      phase = 0;
      while (items_sent < ITEM_COUNT) begin
         phase++;
         settle();
         case (phase)
            2: begin
               w_raw = 8;
               h_raw = 6;
            end
            4: begin
               w_raw = $urandom_range(3, 6);
               h_raw = 16'hFFFF;
            end
            6: begin
               w_raw = 11'h7FF;
               h_raw = 1;
            end
            default: begin
               if ($urandom_range(0, 9) == 0) w_raw = 0;
               else if ($urandom_range(0, 9) == 0) w_raw = $urandom_range(11, 40);
               else w_raw = $urandom_range(1, 10);
               h_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            end
         endcase
         set_geometry(w_raw, h_raw, $urandom_range(0, 1));
         w_eff = (w_raw == 0) ? 1 : ((w_raw > LINE_DEPTH) ? LINE_DEPTH : w_raw);
         h_eff = (h_raw == 0) ? 1 : h_raw;
         if (phase == 4) begin
            // tallest frame: a few rows only, cut off by the next geometry write
            for (k = 0; k < 5 * w_eff; k++) send_item(CMD_PIXEL, rand_pixel());
         end else if (phase == 6) begin
            // widest setting: part of the first row only, cut off the same way
            for (k = 0; k < 20; k++) send_item(CMD_PIXEL, rand_pixel());
         end else if (phase == 2) begin
            run_frame(w_eff, h_eff, 1'b0, 1'b1);
         end else begin
            run_frame(w_eff, h_eff, 1'b1, 1'b0);
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (blur_sb.mismatches == 0 && blur_sb.pending() == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
